// File: src/clcd_pkg.sv
// Shared types, codes and launch helpers for the character LCD refresh controller.
package clcd_pkg;

  localparam int LINE_CHARS_DEF = 16;
  localparam int WAIT_BITS_DEF  = 25;

  localparam int US_W  = 17;         // widest wait in microseconds fits here
  localparam int MUL_W = 8 + US_W;   // ticks_per_us times microseconds

  // Request codes on the action field
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_WRITE   = 3'd1;
  localparam logic [2:0] ACT_REFRESH = 3'd2;
  localparam logic [2:0] ACT_COMMAND = 3'd3;
  localparam logic [2:0] ACT_INIT    = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_FOUR_BIT = 2'd0;
  localparam logic [1:0] CFG_TICKS    = 2'd1;
  localparam logic [1:0] CFG_STROBE   = 2'd2;

  localparam logic       FOUR_BIT_RST = 1'b1;
  localparam logic [7:0] TICKS_RST    = 8'd48;
  localparam logic [7:0] STROBE_RST   = 8'd12;

  // Controller command bytes
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] LINE2_ADDR     = 8'h40;
  localparam logic [7:0] WAKE_WORD      = 8'h30;
  localparam logic [7:0] WAKE_FOUR_BIT  = 8'h20;
  localparam logic [7:0] FUNC_SET_4BIT  = 8'h28;
  localparam logic [7:0] FUNC_SET_8BIT  = 8'h38;
  localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;

  localparam logic [3:0] INIT_IDLE = 4'hF;
  localparam logic [3:0] INIT_LAST = 4'd9;

  typedef enum logic [1:0] {
    WAIT_SHORT,   // 44 us
    WAIT_LONG,    // 1531 us after clear or home
    WAIT_WAKE,    // 100000 us after a wake word
    WAIT_SWITCH   // 10000 us after the switch to nibble mode
  } wait_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HI_SETUP  = 3'd1,
    PH_HI_STROBE = 3'd2,
    PH_HI_HOLD   = 3'd3,
    PH_LO_SETUP  = 3'd4,
    PH_LO_STROBE = 3'd5,
    PH_LO_HOLD   = 3'd6,
    PH_WAIT      = 3'd7
  } phase_t;

  // word[9] is RS, word[7:0] is the byte
  typedef struct packed {
    logic [9:0] word;
    logic       single;
    wait_kind_t kind;
  } launch_t;

  typedef struct packed {
    logic    adv;
    logic    load;
    launch_t launch;
  } xfer_ctl_t;

  typedef struct packed {
    logic active;
    logic active_next;
    logic nibbles;
    logic wait_done;
  } xfer_stat_t;

  typedef struct packed {
    logic       rs;
    logic       e;
    logic [7:0] data;
  } pins_t;

  function automatic logic [US_W-1:0] wait_us(input wait_kind_t kind);
    logic [US_W-1:0] us;
    case (kind)
      WAIT_SHORT:  us = US_W'(44);
      WAIT_LONG:   us = US_W'(1531);
      WAIT_WAKE:   us = US_W'(100000);
      WAIT_SWITCH: us = US_W'(10000);
      default:     us = US_W'(44);
    endcase
    return us;
  endfunction

  function automatic launch_t cmd_launch(input logic [7:0] cmd);
    launch_t l;
    l.word   = {2'b00, cmd};
    l.single = 1'b0;
    l.kind   = (cmd == CMD_CLEAR || cmd == CMD_HOME) ? WAIT_LONG : WAIT_SHORT;
    return l;
  endfunction

  function automatic launch_t char_launch(input logic [7:0] ch);
    launch_t l;
    l.word   = {2'b10, ch};
    l.single = 1'b0;
    l.kind   = WAIT_SHORT;
    return l;
  endfunction

  function automatic launch_t init_launch(input logic [3:0] step, input logic nib);
    launch_t l;
    l = cmd_launch(CMD_DISP_ON);
    case (step)
      4'd0, 4'd1, 4'd2: begin
        l.word   = {2'b00, WAKE_WORD};
        l.single = 1'b1;
        l.kind   = WAIT_WAKE;
      end
      4'd3: begin
        l.word   = {2'b00, WAKE_FOUR_BIT};
        l.single = 1'b1;
        l.kind   = WAIT_SWITCH;
      end
      4'd4:    l = cmd_launch(nib ? FUNC_SET_4BIT : FUNC_SET_8BIT);
      4'd5:    l = cmd_launch(CMD_DISP_OFF);
      4'd6:    l = cmd_launch(CMD_CLEAR);
      4'd7:    l = cmd_launch(CMD_ENTRY_MODE);
      4'd8:    l = cmd_launch(CMD_SET_DDRAM);
      default: l = cmd_launch(CMD_DISP_ON);
    endcase
    return l;
  endfunction

endpackage

// File: src/clcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/clcd_text.sv
// Text store: RAM plus per-entry valid bits so unwritten characters read as zero.
module clcd_text #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_char
);

  logic [DEPTH-1:0] valid;
  logic             rd_valid;
  logic [7:0]       rd_data;

  clcd_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_char = rd_valid ? rd_data : 8'h00;

endmodule

// File: src/clcd_xfer.sv
// Bus transfer engine: setup, strobe and hold phases per nibble or byte, then the wait.
module clcd_xfer #(
  parameter int WAIT_BITS = clcd_pkg::WAIT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   four_bit_mode,
  input  logic [7:0]             ticks_per_us,
  input  logic [7:0]             strobe_ticks,
  input  clcd_pkg::xfer_ctl_t    ctl,
  output clcd_pkg::pins_t        pins_next,
  output clcd_pkg::xfer_stat_t   stat
);
  import clcd_pkg::*;

  localparam int EXT_W = (WAIT_BITS > MUL_W) ? WAIT_BITS : MUL_W;

  phase_t               phase, phase_next;
  logic [7:0]           strobe_count, strobe_count_next;
  logic [WAIT_BITS-1:0] wait_count, wait_count_next;
  logic [9:0]           pending_word, pending_word_next;
  logic                 nibbles, nibbles_next;
  logic                 single, single_next;
  wait_kind_t           kind, kind_next;
  pins_t                pins;

  logic                 strobe_expired;
  logic                 wait_expired;
  logic [MUL_W-1:0]     product;
  logic [EXT_W-1:0]     product_ext;
  logic [WAIT_BITS-1:0] wait_load;

  assign strobe_expired = strobe_count <= 8'd1;
  assign wait_expired   = wait_count <= WAIT_BITS'(1);

  // Wait length in cycles, saturated to the counter
  assign product     = MUL_W'(ticks_per_us) * MUL_W'(wait_us(kind));
  assign product_ext = EXT_W'(product);
  assign wait_load   = (product_ext > EXT_W'({WAIT_BITS{1'b1}})) ? {WAIT_BITS{1'b1}}
                                                                 : product_ext[WAIT_BITS-1:0];

  // Next phase
  always_comb begin
    phase_next = phase;
    if (ctl.load) begin
      phase_next = PH_HI_SETUP;
    end else if (ctl.adv) begin
      case (phase)
        PH_IDLE:      phase_next = PH_IDLE;
        PH_WAIT:      if (wait_expired) phase_next = PH_IDLE;
        PH_HI_SETUP:  if (strobe_expired) phase_next = PH_HI_STROBE;
        PH_HI_STROBE: if (strobe_expired) phase_next = PH_HI_HOLD;
        PH_HI_HOLD: begin
          if (strobe_expired) begin
            phase_next = (nibbles && !single) ? PH_LO_SETUP : PH_WAIT;
          end
        end
        PH_LO_SETUP:  if (strobe_expired) phase_next = PH_LO_STROBE;
        PH_LO_STROBE: if (strobe_expired) phase_next = PH_LO_HOLD;
        PH_LO_HOLD:   if (strobe_expired) phase_next = PH_WAIT;
        default:      phase_next = PH_IDLE;
      endcase
    end
  end

  // Counters, captured word and pin levels
  always_comb begin
    strobe_count_next = strobe_count;
    wait_count_next   = wait_count;
    pending_word_next = pending_word;
    nibbles_next      = nibbles;
    single_next       = single;
    kind_next         = kind;
    pins_next         = pins;
    if (ctl.load) begin
      pending_word_next = ctl.launch.word;
      nibbles_next      = four_bit_mode;
      single_next       = ctl.launch.single;
      kind_next         = ctl.launch.kind;
      strobe_count_next = strobe_ticks;
      pins_next.rs      = ctl.launch.word[9];
      pins_next.e       = 1'b0;
      pins_next.data    = four_bit_mode ? {ctl.launch.word[7:4], 4'h0} : ctl.launch.word[7:0];
    end else if (ctl.adv) begin
      if (phase == PH_WAIT) begin
        wait_count_next = wait_expired ? '0 : wait_count - WAIT_BITS'(1);
      end else if (phase != PH_IDLE) begin
        if (!strobe_expired) begin
          strobe_count_next = strobe_count - 8'd1;
        end else begin
          strobe_count_next = strobe_ticks;
          pins_next.e = (phase_next == PH_HI_STROBE) || (phase_next == PH_LO_STROBE);
          if (phase_next == PH_LO_SETUP) begin
            pins_next.data = {pending_word[3:0], 4'h0};
          end
          if (phase_next == PH_WAIT) begin
            wait_count_next = wait_load;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      strobe_count <= '0;
      wait_count   <= '0;
      pending_word <= '0;
      nibbles      <= 1'b1;
      single       <= 1'b0;
      kind         <= WAIT_SHORT;
      pins         <= '0;
    end else if (ctl.load || ctl.adv) begin
      phase        <= phase_next;
      strobe_count <= strobe_count_next;
      wait_count   <= wait_count_next;
      pending_word <= pending_word_next;
      nibbles      <= nibbles_next;
      single       <= single_next;
      kind         <= kind_next;
      pins         <= pins_next;
    end
  end

  assign stat.active      = phase != PH_IDLE;
  assign stat.active_next = phase_next != PH_IDLE;
  assign stat.nibbles     = nibbles;
  assign stat.wait_done   = ctl.adv && (phase == PH_WAIT) && wait_expired;

endmodule

// File: src/char_lcd_refresh_controller.sv
// Top level of the character LCD refresh controller: handshake, sequencing and text store.
//
// Each input item is one clock tick of bus timing or one request (write a text
// character, start a refresh, send a command, start the init sequence), and each
// item yields exactly one result: the RS/RW/E/D7..D0 levels after that tick, a
// busy flag and whether the request was taken. One item is taken per clock while
// in_stall is low; its result is registered in the output register, and in_stall
// rises only while that register is full and the consumer stalls it. The 2*LINE_CHARS
// text store is a synchronous RAM with a registered read; during a refresh the next
// character is read ahead while the current transfer is still strobing, so a
// refresh step never waits on the memory. Valid bits per entry make the store read
// as zero after reset, so there is no clearing pass. Configuration writes belong in
// idle periods only; the mode is latched at each load, wait and strobe lengths are
// taken as transfers run. Bus timing counts accepted items, not raw clock cycles.
module char_lcd_refresh_controller #(
  parameter int LINE_CHARS = clcd_pkg::LINE_CHARS_DEF,
  parameter int WAIT_BITS  = clcd_pkg::WAIT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_write_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] action,
  input  logic [4:0] char_index,
  input  logic [7:0] char_value,
  input  logic [7:0] command_byte,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       rs_pin,
  output logic       rw_pin,
  output logic       enable_pin,
  output logic [7:0] data_pins,
  output logic       busy_res,
  output logic       accepted
);
  import clcd_pkg::*;

  localparam int TEXT_DEPTH = 2 * LINE_CHARS;
  localparam int ADDR_W     = $clog2(TEXT_DEPTH);
  localparam int SEQ_LEN    = TEXT_DEPTH + 2;   // also the idle value
  localparam int SEQ_W      = $clog2(SEQ_LEN + 1);

  // Configuration registers
  logic       four_bit_mode;
  logic [7:0] ticks_per_us;
  logic [7:0] strobe_ticks;

  // Sequencer state
  logic [SEQ_W-1:0] refresh_step, refresh_step_next;
  logic [3:0]       init_step, init_step_next;

  logic              acc;
  logic              refreshing;
  logic              init_run;
  logic              busy;
  logic              idx_ok;
  logic              took;
  logic              req;
  logic [SEQ_W-1:0]  step_inc;
  logic [3:0]        init_inc;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        next_char;
  xfer_ctl_t         ctl;
  xfer_stat_t        stat;
  pins_t             pins_next;
  logic              busy_next;

  // Handshake: hold off input only while a result waits and is stalled
  assign acc      = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode <= FOUR_BIT_RST;
      ticks_per_us  <= TICKS_RST;
      strobe_ticks  <= STROBE_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_FOUR_BIT: four_bit_mode <= cfg_data[0];
        CFG_TICKS:    ticks_per_us  <= cfg_data;
        CFG_STROBE:   strobe_ticks  <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign refreshing = refresh_step != SEQ_W'(SEQ_LEN);
  assign init_run   = init_step != INIT_IDLE;
  assign busy       = stat.active || refreshing || init_run;
  assign idx_ok     = 32'(char_index) < 32'(TEXT_DEPTH);

  // Decide whether the request is taken; text writes only collide with a refresh
  always_comb begin
    case (action)
      ACT_WRITE:                         took = !refreshing && idx_ok;
      ACT_REFRESH, ACT_COMMAND, ACT_INIT: took = !busy;
      default:                           took = 1'b0;
    endcase
  end

  // A taken refresh, command or init launches its first transfer instead of a tick
  assign req     = took && (action != ACT_WRITE);
  assign ctl.adv = acc && !req;

  assign step_inc = refresh_step + SEQ_W'(1);
  assign init_inc = (!stat.nibbles && init_step == 4'd2) ? 4'd4 : init_step + 4'd1;

  // Launch selection and sequence advance
  always_comb begin
    refresh_step_next = refresh_step;
    init_step_next    = init_step;
    ctl.load          = 1'b0;
    ctl.launch        = cmd_launch(CMD_SET_DDRAM);
    if (acc && req) begin
      ctl.load = 1'b1;
      case (action)
        ACT_REFRESH: begin
          refresh_step_next = '0;
          ctl.launch        = cmd_launch(CMD_SET_DDRAM);
        end
        ACT_COMMAND: ctl.launch = cmd_launch(command_byte);
        ACT_INIT: begin
          init_step_next = 4'd0;
          ctl.launch     = init_launch(4'd0, four_bit_mode);
        end
        default: ctl.load = 1'b0;
      endcase
    end else if (stat.wait_done) begin
      if (refreshing) begin
        refresh_step_next = step_inc;
        if (step_inc != SEQ_W'(SEQ_LEN)) begin
          ctl.load = 1'b1;
          if (step_inc == SEQ_W'(LINE_CHARS + 1)) begin
            ctl.launch = cmd_launch(CMD_SET_DDRAM | LINE2_ADDR);
          end else begin
            ctl.launch = char_launch(next_char);
          end
        end
      end else if (init_run) begin
        if (init_inc > INIT_LAST) begin
          init_step_next = INIT_IDLE;
        end else begin
          init_step_next = init_inc;
          ctl.load       = 1'b1;
          ctl.launch     = init_launch(init_inc, stat.nibbles);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_step <= SEQ_W'(SEQ_LEN);
      init_step    <= INIT_IDLE;
    end else if (acc) begin
      refresh_step <= refresh_step_next;
      init_step    <= init_step_next;
    end
  end

  // Read ahead the character for the step after the current one; the store
  // cannot change while a refresh runs
  always_comb begin
    if (refresh_step < SEQ_W'(LINE_CHARS)) begin
      rd_addr = ADDR_W'(refresh_step);
    end else if (refresh_step <= SEQ_W'(TEXT_DEPTH)) begin
      rd_addr = ADDR_W'(refresh_step - SEQ_W'(1));
    end else begin
      rd_addr = '0;
    end
  end

  clcd_text #(
    .DEPTH(TEXT_DEPTH)
  ) u_text (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (acc && took && action == ACT_WRITE),
    .wr_addr (ADDR_W'(char_index)),
    .wr_data (char_value),
    .rd_addr (rd_addr),
    .rd_char (next_char)
  );

  clcd_xfer #(
    .WAIT_BITS(WAIT_BITS)
  ) u_xfer (
    .clk           (clk),
    .rst           (rst),
    .four_bit_mode (four_bit_mode),
    .ticks_per_us  (ticks_per_us),
    .strobe_ticks  (strobe_ticks),
    .ctl           (ctl),
    .pins_next     (pins_next),
    .stat          (stat)
  );

  assign busy_next = stat.active_next || (refresh_step_next != SEQ_W'(SEQ_LEN)) ||
                     (init_step_next != INIT_IDLE);

  // Output register: capture each result on transfer in, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rs_pin     <= pins_next.rs;
      enable_pin <= pins_next.e;
      data_pins  <= pins_next.data;
      busy_res   <= busy_next;
      accepted   <= took;
    end
  end

  // Writes only; the bus is never read
  assign rw_pin = 1'b0;

  a_busy_refused: assert property (@(posedge clk) disable iff (rst)
    acc && busy && (action == ACT_REFRESH || action == ACT_COMMAND || action == ACT_INIT)
    |=> !accepted)
    else $error("launch request taken while busy");

  a_refresh_range: assert property (@(posedge clk) disable iff (rst)
    refresh_step <= SEQ_W'(SEQ_LEN))
    else $error("refresh step out of range");

  a_init_range: assert property (@(posedge clk) disable iff (rst)
    init_step <= INIT_LAST || init_step == INIT_IDLE)
    else $error("init step out of range");

  a_one_sequence: assert property (@(posedge clk) disable iff (rst)
    !(refreshing && init_run))
    else $error("refresh and init running together");

  a_seq_needs_xfer: assert property (@(posedge clk) disable iff (rst)
    acc && stat.wait_done && refreshing && step_inc != SEQ_W'(SEQ_LEN) |=> stat.active)
    else $error("refresh step advanced without launching a transfer");

endmodule

// File: tb/char_lcd_refresh_controller_tb.sv
// Self-checking testbench for the character LCD refresh controller.
module char_lcd_refresh_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clcd_pkg::*;

  localparam int TEXT_LEN  = 2 * LINE_CHARS_DEF;
  localparam int SEQ_STEPS = TEXT_LEN + 2;
  localparam longint unsigned WAIT_MAX = (64'd1 << WAIT_BITS_DEF) - 64'd1;

  // Wait lengths in microseconds
  localparam int unsigned US_SHORT  = 44;
  localparam int unsigned US_LONG   = 1531;
  localparam int unsigned US_WAKE   = 100000;
  localparam int unsigned US_SWITCH = 10000;

  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [2:0] action;
    logic [4:0] idx;
    logic [7:0] chr;
    logic [7:0] cmd;
  } lcd_req_t;

  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       e;
    logic [7:0] data;
    logic       busy;
    logic       took;
  } bus_levels_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] action = '0;
  logic [4:0] char_index = '0;
  logic [7:0] char_value = '0;
  logic [7:0] command_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       rs_pin;
  logic       rw_pin;
  logic       enable_pin;
  logic [7:0] data_pins;
  logic       busy_res;
  logic       accepted;

  char_lcd_refresh_controller i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .char_index   (char_index),
    .char_value   (char_value),
    .command_byte (command_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rs_pin       (rs_pin),
    .rw_pin       (rw_pin),
    .enable_pin   (enable_pin),
    .data_pins    (data_pins),
    .busy_res     (busy_res),
    .accepted     (accepted)
  );

  always #5 clk = ~clk;

  // Requests waiting to go out, and the bus levels each one must produce
  lcd_req_t    item_q[$];
  bus_levels_t bus_expect_q[$];

  int err_count = 0;
  int rx_count = 0;
  int holds_done = 0;
  int n_refresh = 0, n_init = 0, n_cmd = 0, n_write = 0, n_refused = 0;

  // ---------------------------------------------------------------------------
  // Bus predictor: its own copy of configuration, text image and transfer state
  // ---------------------------------------------------------------------------
  logic        cfg_nib;
  logic [7:0]  cfg_tpu;
  logic [7:0]  cfg_stb;
  logic [7:0]  text_img [TEXT_LEN];
  int unsigned refresh_pos;
  logic [3:0]  init_pos;
  logic [31:0] wait_left;
  logic [7:0]  strobe_left;
  phase_t      xfer_ph;
  logic [9:0]  word_out;
  logic        pin_rs, pin_e;
  logic [7:0]  pin_data;
  logic        xfer_nib, xfer_one;

  function automatic logic lcd_busy();
    return xfer_ph != PH_IDLE || refresh_pos < SEQ_STEPS || init_pos != INIT_IDLE;
  endfunction

  // Load a transfer: setup levels show at once, mode and wait length are latched here
  task automatic start_word(input logic [9:0] w, input logic one, input int unsigned us);
    longint unsigned cyc;
    cyc         = 64'(cfg_tpu) * 64'(us);
    word_out    = w;
    xfer_nib    = cfg_nib;
    xfer_one    = one;
    pin_rs      = w[9];
    pin_e       = 1'b0;
    pin_data    = cfg_nib ? {w[7:4], 4'h0} : w[7:0];
    xfer_ph     = PH_HI_SETUP;
    strobe_left = cfg_stb;
    wait_left   = (cyc > WAIT_MAX) ? 32'(WAIT_MAX) : 32'(cyc);
  endtask

  task automatic start_cmd(input logic [7:0] c);
    start_word({2'b00, c}, 1'b0, (c == CMD_CLEAR || c == CMD_HOME) ? US_LONG : US_SHORT);
  endtask

  task automatic start_refresh_step(input int unsigned s);
    if (s == 0)
      start_cmd(CMD_SET_DDRAM);
    else if (s <= LINE_CHARS_DEF)
      start_word({2'b10, text_img[s - 1]}, 1'b0, US_SHORT);
    else if (s == LINE_CHARS_DEF + 1)
      start_cmd(CMD_SET_DDRAM | LINE2_ADDR);
    else
      start_word({2'b10, text_img[s - 2]}, 1'b0, US_SHORT);
  endtask

  task automatic start_init_step(input logic [3:0] s);
    case (s)
      4'd0, 4'd1, 4'd2: start_word({2'b00, WAKE_WORD}, 1'b1, US_WAKE);
      4'd3:             start_word({2'b00, WAKE_FOUR_BIT}, 1'b1, US_SWITCH);
      4'd4:             start_cmd(xfer_nib ? FUNC_SET_4BIT : FUNC_SET_8BIT);
      4'd5:             start_cmd(CMD_DISP_OFF);
      4'd6:             start_cmd(CMD_CLEAR);
      4'd7:             start_cmd(CMD_ENTRY_MODE);
      4'd8:             start_cmd(CMD_SET_DDRAM);
      default:          start_cmd(CMD_DISP_ON);
    endcase
  endtask

  // Move to the next refresh or init step once a wait has run out
  task automatic sequence_next();
    logic nib;
    if (refresh_pos < SEQ_STEPS) begin
      refresh_pos++;
      if (refresh_pos < SEQ_STEPS) start_refresh_step(refresh_pos);
    end else if (init_pos != INIT_IDLE) begin
      nib = xfer_nib;
      init_pos++;
      // 8-bit mode has no switch-to-nibble wake step
      if (!nib && init_pos == 4'd3) init_pos = 4'd4;
      if (init_pos > INIT_LAST) begin
        init_pos = INIT_IDLE;
      end else begin
        xfer_nib = nib;
        start_init_step(init_pos);
      end
    end
  endtask

  // One tick of bus timing
  task automatic bus_advance();
    if (xfer_ph == PH_WAIT) begin
      if (wait_left > 1) begin
        wait_left--;
      end else begin
        wait_left = '0;
        xfer_ph   = PH_IDLE;
        sequence_next();
      end
    end else if (xfer_ph != PH_IDLE) begin
      if (strobe_left > 1) begin
        strobe_left--;
      end else begin
        // a strobe length of zero behaves as one
        strobe_left = cfg_stb;
        case (xfer_ph)
          PH_HI_SETUP: begin
            pin_e   = 1'b1;
            xfer_ph = PH_HI_STROBE;
          end
          PH_LO_SETUP: begin
            pin_e   = 1'b1;
            xfer_ph = PH_LO_STROBE;
          end
          PH_HI_STROBE: begin
            pin_e   = 1'b0;
            xfer_ph = PH_HI_HOLD;
          end
          PH_LO_STROBE: begin
            pin_e   = 1'b0;
            xfer_ph = PH_LO_HOLD;
          end
          PH_HI_HOLD: begin
            if (xfer_nib && !xfer_one) begin
              pin_data = {word_out[3:0], 4'h0};
              xfer_ph  = PH_LO_SETUP;
            end else begin
              xfer_ph = PH_WAIT;
            end
          end
          default: xfer_ph = PH_WAIT;
        endcase
      end
    end
  endtask

  // Apply one request and return the bus levels and flags it leaves behind
  task automatic bus_step(input lcd_req_t r, output bus_levels_t lv);
    logic refreshing, busy, took;
    refreshing = refresh_pos < SEQ_STEPS;
    busy       = lcd_busy();
    took       = 1'b0;
    if (r.action == ACT_WRITE) begin
      // text writes are refused only while a refresh reads the store
      if (!refreshing && r.idx < TEXT_LEN) begin
        text_img[r.idx] = r.chr;
        took = 1'b1;
      end
    end else if ((r.action == ACT_REFRESH || r.action == ACT_COMMAND ||
                  r.action == ACT_INIT) && !busy) begin
      took = 1'b1;
      case (r.action)
        ACT_REFRESH: begin
          refresh_pos = 0;
          start_refresh_step(0);
        end
        ACT_COMMAND: start_cmd(r.cmd);
        default: begin
          init_pos = 4'd0;
          xfer_nib = cfg_nib;
          start_init_step(4'd0);
        end
      endcase
    end
    // a request that loads a transfer holds timing for this tick
    if (!(took && r.action != ACT_WRITE)) bus_advance();
    lv.rs   = pin_rs;
    lv.rw   = 1'b0;
    lv.e    = pin_e;
    lv.data = pin_data;
    lv.busy = lcd_busy();
    lv.took = took;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_req(input logic [2:0] a, input logic [4:0] i, input logic [7:0] c,
                           input logic [7:0] m);
    lcd_req_t    r;
    bus_levels_t lv;
    r = '{action: a, idx: i, chr: c, cmd: m};
    bus_step(r, lv);
    item_q.push_back(r);
    bus_expect_q.push_back(lv);
    if (lv.took) begin
      case (a)
        ACT_REFRESH: n_refresh++;
        ACT_INIT:    n_init++;
        ACT_COMMAND: n_cmd++;
        default:     n_write++;
      endcase
    end else if (a >= ACT_WRITE && a <= ACT_INIT) begin
      n_refused++;
    end
  endtask

  // Tick until the predicted controller has gone idle
  task automatic drain_busy();
    while (lcd_busy()) queue_req(ACT_TICK, 5'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Mostly well-formed traffic: requests while idle, ticks while busy, some noise
  task automatic queue_random(input int n, input bit allow_init);
    int         w;
    logic [2:0] a;
    logic [7:0] c;
    for (int k = 0; k < n; k++) begin
      w = $urandom_range(0, 99);
      c = 8'($urandom);
      if ($urandom_range(0, 7) == 0) c = $urandom_range(0, 1) ? CMD_CLEAR : CMD_HOME;
      if (lcd_busy()) begin
        if (w < 78)      a = ACT_TICK;
        else if (w < 88) a = ACT_WRITE;
        else if (w < 95) a = 3'($urandom_range(ACT_REFRESH, ACT_INIT));
        else             a = 3'($urandom_range(5, 7));
      end else begin
        if (w < 38)      a = ACT_REFRESH;
        else if (w < 60) a = ACT_COMMAND;
        else if (w < 72) a = allow_init ? ACT_INIT : ACT_REFRESH;
        else if (w < 87) a = ACT_WRITE;
        else if (w < 95) a = ACT_TICK;
        else             a = 3'($urandom_range(5, 7));
      end
      queue_req(a, 5'($urandom), 8'($urandom), c);
    end
  endtask

  // Wait until every queued request has produced its result
  task automatic settle();
    while (item_q.size() != 0 || bus_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_FOUR_BIT: cfg_nib = val[0];
      CFG_TICKS:    cfg_tpu = val;
      default:      cfg_stb = val;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      err_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: feed requests from the queue in bursts with random gaps
  // ---------------------------------------------------------------------------
  logic in_took = 1'b0;   // a transfer happened on the input at the last rising edge
  int   burst_left = 0;
  int   gap_left = 0;

  always @(posedge clk) begin
    in_took <= !rst && in_valid && !in_stall;
  end

  always @(negedge clk) begin : feed
    logic waiting;
    waiting = in_valid && !in_took;
    // drop the request the block just took
    if (in_took) item_q.delete(0);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!waiting) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        in_valid     <= 1'b1;
        action       <= item_q[0].action;
        char_index   <= item_q[0].idx;
        char_value   <= item_q[0].chr;
        command_byte <= item_q[0].cmd;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // end of burst: pick the next burst length and the pause after it
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
    // otherwise hold the stalled payload as it is
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern of its own, with two long hold-offs
  // ---------------------------------------------------------------------------
  int pace_left = 0;
  int pace_mode = 0;
  int hold_left = 0;

  always @(negedge clk) begin : sink_pace
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if ((rx_count >= 400 && holds_done == 0) ||
                 (rx_count >= 1600 && holds_done == 1)) begin
      // hold off long enough for the block to back up into its input
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (pace_left == 0) begin
        pace_mode = $urandom_range(0, 2);
        pace_left = $urandom_range(20, 120);
      end else begin
        pace_left--;
      end
      case (pace_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_out
    bus_levels_t want;
    if (!rst && out_valid && !out_stall) begin
      rx_count++;
      if (bus_expect_q.size() == 0) begin
        $display("%0t ns: result with none expected, got rs=%0d rw=%0d e=%0d data=0x%0h busy=%0d acc=%0d",
                 $time, rs_pin, rw_pin, enable_pin, data_pins, busy_res, accepted);
        err_count++;
      end else begin
        want = bus_expect_q.pop_front();
        check_field("rs_pin", want.rs, rs_pin);
        check_field("rw_pin", want.rw, rw_pin);
        check_field("enable_pin", want.e, enable_pin);
        check_field("data_pins", want.data, data_pins);
        check_field("busy_res", want.busy, busy_res);
        check_field("accepted", want.took, accepted);
      end
    end
  end

  // Watchdog: count cycles with work pending but no transfer on either side
  int stuck_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (item_q.size() == 0 && bus_expect_q.size() == 0)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles, %0d results still due",
                 $time, stuck_cycles, bus_expect_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // predictor starts from the reset state of the block
    cfg_nib     = FOUR_BIT_RST;
    cfg_tpu     = TICKS_RST;
    cfg_stb     = STROBE_RST;
    foreach (text_img[k]) text_img[k] = '0;
    refresh_pos = SEQ_STEPS;
    init_pos    = INIT_IDLE;
    wait_left   = '0;
    strobe_left = '0;
    xfer_ph     = PH_IDLE;
    word_out    = '0;
    pin_rs      = 1'b0;
    pin_e       = 1'b0;
    pin_data    = '0;
    xfer_nib    = 1'b1;
    xfer_one    = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: field extremes, unused actions, text writes, a command and busy refusals
    queue_req(ACT_TICK, 5'd0, 8'h00, 8'h00);
    queue_req(ACT_TICK, 5'd31, 8'hFF, 8'hFF);
    queue_req(3'd5, 5'd3, 8'h12, 8'h34);
    queue_req(3'd6, 5'd7, 8'h56, 8'h78);
    queue_req(3'd7, 5'd31, 8'hFF, 8'hFF);
    queue_req(ACT_WRITE, 5'd0, 8'hFF, 8'h00);
    queue_req(ACT_WRITE, 5'd31, 8'h00, 8'hFF);
    queue_req(ACT_WRITE, 5'd15, 8'hA5, 8'h00);
    queue_req(ACT_WRITE, 5'd16, 8'h5A, 8'h00);
    queue_req(ACT_COMMAND, 5'd0, 8'h00, 8'hFF);
    queue_req(ACT_REFRESH, 5'd0, 8'h00, 8'h00);
    queue_req(ACT_COMMAND, 5'd0, 8'h00, 8'h00);
    queue_req(ACT_INIT, 5'd0, 8'h00, 8'h00);
    queue_req(ACT_WRITE, 5'd7, 8'h41, 8'h00);
    drain_busy();
    settle();

    // Byte mode with the fastest timing: init, refresh, clear, home
    write_reg(CFG_FOUR_BIT, 8'd0);
    write_reg(CFG_TICKS, 8'd0);
    write_reg(CFG_STROBE, 8'd1);
    queue_req(ACT_INIT, 5'd0, 8'h00, 8'h00);
    drain_busy();
    queue_req(ACT_REFRESH, 5'd0, 8'h00, 8'h00);
    queue_req(ACT_WRITE, 5'd4, 8'h77, 8'h00);   // refused while refreshing
    drain_busy();
    queue_req(ACT_COMMAND, 5'd0, 8'h00, CMD_CLEAR);
    drain_busy();
    queue_req(ACT_COMMAND, 5'd0, 8'h00, CMD_HOME);
    drain_busy();
    queue_random(550, 1'b1);
    drain_busy();
    settle();

    // Nibble mode, fastest timing
    write_reg(CFG_FOUR_BIT, 8'd1);
    queue_req(ACT_INIT, 5'd0, 8'h00, 8'h00);
    drain_busy();
    queue_req(ACT_REFRESH, 5'd0, 8'h00, 8'h00);
    drain_busy();
    queue_random(550, 1'b1);
    drain_busy();
    settle();

    // Nibble mode with one tick per microsecond; init waits are too long here
    write_reg(CFG_TICKS, 8'd1);
    write_reg(CFG_STROBE, 8'd3);
    queue_random(350, 1'b0);
    drain_busy();
    settle();

    // Slowest strobe and a high tick rate, in both modes
    write_reg(CFG_FOUR_BIT, 8'd0);
    write_reg(CFG_TICKS, 8'd200);
    write_reg(CFG_STROBE, 8'd255);
    queue_req(ACT_COMMAND, 5'd0, 8'h00, 8'hC7);
    drain_busy();
    settle();
    write_reg(CFG_FOUR_BIT, 8'd1);
    queue_req(ACT_COMMAND, 5'd0, 8'h00, 8'h5A);
    queue_req(ACT_WRITE, 5'd9, 8'h3C, 8'h00);
    drain_busy();
    settle();

    // Zero strobe length behaves as one
    write_reg(CFG_TICKS, 8'd0);
    write_reg(CFG_STROBE, 8'd0);
    queue_random(300, 1'b1);
    drain_busy();
    settle();

    repeat (20) @(posedge clk);

    $display("Checked %0d results: %0d refreshes, %0d init runs, %0d commands, %0d text writes",
             rx_count, n_refresh, n_init, n_cmd, n_write);
    $display("%0d requests refused, %0d long receiver hold-offs", n_refused, holds_done);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
